/* sv/pixel_tint_blend_unit_macros.svh */
// Assertion macros shared by the pixel tint blend unit.
`ifndef PIXEL_TINT_BLEND_UNIT_MACROS_SVH
`define PIXEL_TINT_BLEND_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Plain property, checked at every clock edge outside reset.
`define PTB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pixel_tint_blend_unit: check failed");
// Overlapping implication, checked outside reset.
`define PTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pixel_tint_blend_unit: check failed");
`else
`define PTB_ASSERT(lbl, clk, rst_n, prop)
`define PTB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ptb_pkg.sv */
// Types, constants and fixed-point helpers of the pixel tint blend unit.
package ptb_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FX_ONE      = 1 << FRAC_BITS;
    localparam int FX_HALF     = 1 << (FRAC_BITS - 1);
    localparam int COORD_LIMIT = 4096;

    // Luminosity weights in Q0.16, rounded to nearest; they sum to one.
    localparam logic [15:0] W_RED   = 16'((30 * FX_ONE + 50) / 100);
    localparam logic [15:0] W_GREEN = 16'((59 * FX_ONE + 50) / 100);
    localparam logic [15:0] W_BLUE  = 16'((11 * FX_ONE + 50) / 100);

    typedef enum logic [1:0] {
        MODE_OVERLAY = 2'd0,
        MODE_COLOR   = 2'd1,
        MODE_NORMAL  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        CFG_BLEND_MODE     = 3'd0,
        CFG_TINT_RGB       = 3'd1,
        CFG_OPACITY        = 3'd2,
        CFG_REGION_X_START = 3'd3,
        CFG_REGION_X_END   = 3'd4,
        CFG_REGION_Y_START = 3'd5,
        CFG_REGION_Y_END   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [7:0]  in_alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_pix_out;

    typedef struct packed {
        logic [1:0]  blend_mode;
        logic [23:0] tint_rgb;
        logic [8:0]  opacity;
        logic [12:0] region_x_start;
        logic [12:0] region_x_end;
        logic [12:0] region_y_start;
        logic [12:0] region_y_end;
    } t_cfg;

    // State of one item along the color clip pipeline. Channel values r and
    // mx are two's complement Q2.16; l is the backdrop luminosity.
    typedef struct packed {
        t_pix_out          orig;
        logic              tinted;
        logic [2:0][16:0]  ov;
        logic [2:0][18:0]  r;
        logic [16:0]       l;
        logic [18:0]       mx;
        logic              clip;
        logic [2:0]        neg;
    } t_side;

    // 8-bit channel to Q0.16: (v * 65536 + 127) / 255 equals v * 257 + v[7].
    function automatic logic [16:0] to_fx(input logic [7:0] v);
        return 17'({v, 8'd0}) + 17'(v) + 17'(v[7]);
    endfunction

    // Q0.16 to 8 bits: clamp to [0, one], then (c * 255 + half) >> 16.
    function automatic logic [7:0] to_u8(input logic signed [18:0] c);
        logic [16:0] u;
        logic [25:0] w;
        if (c < 0) begin
            u = '0;
        end else if (c > FX_ONE) begin
            u = 17'(FX_ONE);
        end else begin
            u = c[16:0];
        end
        w = 26'({u, 8'd0}) - 26'(u) + 26'(FX_HALF);
        return w[FRAC_BITS+7:FRAC_BITS];
    endfunction

endpackage

/* sv/ptb_front.sv */
// Front stages: region test, to Q0.16, overlay, luminosity and tint shift.
module ptb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptb_pkg::t_pix_in  i_item,
    input  ptb_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output ptb_pkg::t_side    o_side
);

    logic                  r_v1, r_v2, r_v3;
    ptb_pkg::t_pix_out     r_orig1, r_orig2;
    logic                  r_tint1, r_tint2;
    logic [2:0][16:0]      r_b1, r_s1, r_s2, r_ov2;
    logic [32:0]           r_lsb2, r_lss2;
    ptb_pkg::t_side        r_side3;

    logic                  n_tint1;
    logic [2:0][16:0]      n_b1, n_s1, n_ov2;
    logic [32:0]           n_lsb2, n_lss2;
    ptb_pkg::t_side        n_side3;

    // Stage one: region and alpha test, channels to Q0.16.
    always_comb begin
        logic [12:0] xe;
        logic [12:0] ye;
        logic [7:0]  orig [3];
        xe = (i_cfg.region_x_end > 13'(ptb_pkg::COORD_LIMIT)) ?
             13'(ptb_pkg::COORD_LIMIT) : i_cfg.region_x_end;
        ye = (i_cfg.region_y_end > 13'(ptb_pkg::COORD_LIMIT)) ?
             13'(ptb_pkg::COORD_LIMIT) : i_cfg.region_y_end;
        orig[0] = i_item.in_red;
        orig[1] = i_item.in_green;
        orig[2] = i_item.in_blue;
        n_tint1 = (i_item.in_alpha != 8'd0)
                && ({1'b0, i_item.pixel_x} >= i_cfg.region_x_start)
                && ({1'b0, i_item.pixel_x} < xe)
                && ({1'b0, i_item.pixel_y} >= i_cfg.region_y_start)
                && ({1'b0, i_item.pixel_y} < ye);
        for (int i = 0; i < 3; i++) begin
            n_b1[i] = ptb_pkg::to_fx(orig[i]);
            n_s1[i] = ptb_pkg::to_fx(i_cfg.tint_rgb[23-8*i -: 8]);
        end
    end

    // Stage two: overlay per channel and luminosity products.
    always_comb begin
        logic [34:0] p;
        logic [34:0] q;
        for (int i = 0; i < 3; i++) begin
            if (r_b1[i] <= 17'(ptb_pkg::FX_HALF)) begin
                p = 35'({r_b1[i], 1'b0}) * 35'(r_s1[i]);
                q = (p + 35'(ptb_pkg::FX_HALF)) >> ptb_pkg::FRAC_BITS;
                n_ov2[i] = q[16:0];
            end else begin
                p = 35'({17'(ptb_pkg::FX_ONE) - r_b1[i], 1'b0})
                  * 35'(17'(ptb_pkg::FX_ONE) - r_s1[i]);
                q = (p + 35'(ptb_pkg::FX_HALF)) >> ptb_pkg::FRAC_BITS;
                n_ov2[i] = 17'(ptb_pkg::FX_ONE) - q[16:0];
            end
        end
        n_lsb2 = 33'(ptb_pkg::W_RED) * 33'(r_b1[0]) + 33'(ptb_pkg::W_GREEN) * 33'(r_b1[1])
               + 33'(ptb_pkg::W_BLUE) * 33'(r_b1[2]);
        n_lss2 = 33'(ptb_pkg::W_RED) * 33'(r_s1[0]) + 33'(ptb_pkg::W_GREEN) * 33'(r_s1[1])
               + 33'(ptb_pkg::W_BLUE) * 33'(r_s1[2]);
    end

    // Stage three: round the lumas and shift the tint to the backdrop luma.
    // The shifted color has the backdrop luminosity up to rounding.
    always_comb begin
        logic [32:0]        lb;
        logic [32:0]        ls;
        logic signed [19:0] d;
        lb = (r_lsb2 + 33'(ptb_pkg::FX_HALF)) >> ptb_pkg::FRAC_BITS;
        ls = (r_lss2 + 33'(ptb_pkg::FX_HALF)) >> ptb_pkg::FRAC_BITS;
        d  = 20'($signed({1'b0, lb[16:0]})) - 20'($signed({1'b0, ls[16:0]}));
        n_side3        = '0;
        n_side3.orig   = r_orig2;
        n_side3.tinted = r_tint2;
        n_side3.ov     = r_ov2;
        n_side3.l      = lb[16:0];
        for (int i = 0; i < 3; i++) begin
            n_side3.r[i] = 19'(20'($signed({1'b0, r_s2[i]})) + d);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_orig1 <= '{i_item.in_red, i_item.in_green, i_item.in_blue, i_item.in_alpha};
        r_tint1 <= n_tint1;
        r_b1    <= n_b1;
        r_s1    <= n_s1;
        r_orig2 <= r_orig1;
        r_tint2 <= r_tint1;
        r_s2    <= r_s1;
        r_ov2   <= n_ov2;
        r_lsb2  <= n_lsb2;
        r_lss2  <= n_lss2;
        r_side3 <= n_side3;
    end

    assign o_valid = r_v3;
    assign o_side  = r_side3;

endmodule

/* sv/ptb_div.sv */
// Pipelined restoring divider, one quotient bit per stage, three channels.
module ptb_div #(
    parameter int NW = 35,
    parameter int DW = 18,
    parameter int QW = 18,
    parameter int SW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [2:0][NW-1:0]   i_num,
    input  logic [DW-1:0]        i_den,
    input  logic [SW-1:0]        i_side,
    output logic                 o_valid,
    output logic [2:0][QW-1:0]   o_quo,
    output logic [SW-1:0]        o_side
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW-1:0]         r_v;
    logic [2:0][NW-1:0]    r_rem  [QW];
    logic [2:0][QW-1:0]    r_quo  [QW];
    logic [DW-1:0]         r_den  [QW];
    logic [SW-1:0]         r_side [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int K = QW - 1 - g;
        logic               a_v;
        logic [2:0][NW-1:0] a_rem;
        logic [2:0][QW-1:0] a_quo;
        logic [DW-1:0]      a_den;
        logic [SW-1:0]      a_side;
        logic [CW-1:0]      sub;
        logic [2:0][NW-1:0] n_rem;
        logic [2:0][QW-1:0] n_quo;

        if (g == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_rem  = i_num;
            assign a_quo  = '0;
            assign a_den  = i_den;
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[g-1];
            assign a_rem  = r_rem[g-1];
            assign a_quo  = r_quo[g-1];
            assign a_den  = r_den[g-1];
            assign a_side = r_side[g-1];
        end

        assign sub = CW'(a_den) << K;

        // Trial subtraction of the shifted divisor decides one quotient bit.
        always_comb begin
            for (int c = 0; c < 3; c++) begin
                if (CW'(a_rem[c]) >= sub) begin
                    n_rem[c] = NW'(CW'(a_rem[c]) - sub);
                    n_quo[c] = a_quo[c] | (QW'(1) << K);
                end else begin
                    n_rem[c] = a_rem[c];
                    n_quo[c] = a_quo[c];
                end
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= a_v;
            end
        end

        // Payload of this stage.
        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_quo[g]  <= n_quo;
            r_den[g]  <= a_den;
            r_side[g] <= a_side;
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

/* sv/ptb_back.sv */
// Back stages: blend mode select, conversion to 8 bits, opacity mix.
module ptb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ptb_pkg::t_side    i_side,
    input  ptb_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    output ptb_pkg::t_pix_out o_item
);

    logic              r_v1, r_v2;
    logic [2:0][7:0]   r_bl1;
    ptb_pkg::t_pix_out r_orig1;
    logic              r_tint1;
    ptb_pkg::t_pix_out r_out2;

    logic [2:0][7:0]   n_bl1;
    ptb_pkg::t_pix_out n_out2;

    // Blended color by mode; unused mode code acts as normal replace.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (i_cfg.blend_mode)
                ptb_pkg::MODE_OVERLAY: n_bl1[i] = ptb_pkg::to_u8($signed({2'b0, i_side.ov[i]}));
                ptb_pkg::MODE_COLOR:   n_bl1[i] = ptb_pkg::to_u8($signed(i_side.r[i]));
                default:               n_bl1[i] = i_cfg.tint_rgb[23-8*i -: 8];
            endcase
        end
    end

    // Mix the blended color over the original by the opacity, saturated at 256.
    always_comb begin
        logic [8:0]  op;
        logic [16:0] w;
        logic [7:0]  orig [3];
        logic [7:0]  res  [3];
        op = (i_cfg.opacity > 9'd256) ? 9'd256 : i_cfg.opacity;
        orig[0] = r_orig1.out_red;
        orig[1] = r_orig1.out_green;
        orig[2] = r_orig1.out_blue;
        for (int i = 0; i < 3; i++) begin
            w = 17'(orig[i]) * 17'(9'd256 - op) + 17'(r_bl1[i]) * 17'(op) + 17'd128;
            res[i] = r_tint1 ? w[15:8] : orig[i];
        end
        n_out2 = '{res[0], res[1], res[2], r_orig1.out_alpha};
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_bl1   <= n_bl1;
        r_orig1 <= i_side.orig;
        r_tint1 <= i_side.tinted;
        r_out2  <= n_out2;
    end

    assign o_valid = r_v2;
    assign o_item  = r_out2;

endmodule

/* sv/pixel_tint_blend_unit.sv */
// Pixel tint blend unit: top level with configuration, color clip stages and checks.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+----------------------------------
//  input     | start, busy           | i_item (coordinates, RGBA)
//  result    | o_valid (one cycle)   | o_item (RGBA)
//  config    | i_cfg_we              | i_cfg_idx, i_cfg_data
//
// One item is taken every cycle; busy stays low. Each item passes
// through the two 18-stage clip dividers plus nine stages of front,
// clip and back logic. The result side cannot stall, so the pipeline
// always advances. Synchronous reset clears the valid bits and loads
// the register reset values.
`include "pixel_tint_blend_unit_macros.svh"

module pixel_tint_blend_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ptb_pkg::t_pix_in   i_item,
    output logic               o_valid,
    output ptb_pkg::t_pix_out  o_item,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);

    localparam int NW  = 35;
    localparam int DW  = 18;
    localparam int QW  = 18;
    localparam int SW  = $bits(ptb_pkg::t_side);
    localparam int LAT = 9 + 2 * QW;

    ptb_pkg::t_cfg        r_cfg;

    logic                 f_valid;
    ptb_pkg::t_side       f_side;

    logic                 r_v4, r_v5, r_v6, r_v7;
    ptb_pkg::t_side       r_side4, r_side5, r_side6, r_side7;
    logic [2:0][NW-1:0]   r_prod4, r_prod6;
    logic [DW-1:0]        r_den4, r_den6;

    ptb_pkg::t_side       n_side4, n_side5, n_side6, n_side7;
    logic [2:0][NW-1:0]   n_prod4, n_prod6;
    logic [DW-1:0]        n_den4, n_den6;

    logic                 d1_valid, d2_valid;
    logic [2:0][QW-1:0]   d1_quo, d2_quo;
    logic [SW-1:0]        d1_side, d2_side;
    ptb_pkg::t_side       d1_s, d2_s;

    logic                 accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blend_mode     <= ptb_pkg::MODE_OVERLAY;
            r_cfg.tint_rgb       <= 24'hFFFFFF;
            r_cfg.opacity        <= 9'd256;
            r_cfg.region_x_start <= 13'd0;
            r_cfg.region_x_end   <= 13'd4096;
            r_cfg.region_y_start <= 13'd0;
            r_cfg.region_y_end   <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptb_pkg::CFG_BLEND_MODE:     r_cfg.blend_mode     <= i_cfg_data[1:0];
                ptb_pkg::CFG_TINT_RGB:       r_cfg.tint_rgb       <= i_cfg_data;
                ptb_pkg::CFG_OPACITY:        r_cfg.opacity        <= i_cfg_data[8:0];
                ptb_pkg::CFG_REGION_X_START: r_cfg.region_x_start <= i_cfg_data[12:0];
                ptb_pkg::CFG_REGION_X_END:   r_cfg.region_x_end   <= i_cfg_data[12:0];
                ptb_pkg::CFG_REGION_Y_START: r_cfg.region_y_start <= i_cfg_data[12:0];
                ptb_pkg::CFG_REGION_Y_END:   r_cfg.region_y_end   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    ptb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_item),
        .i_cfg   (r_cfg),
        .o_valid (f_valid),
        .o_side  (f_side)
    );

    // Low clip setup: extremes, distances from luma, products with the luma.
    always_comb begin
        logic signed [18:0] mn;
        logic signed [18:0] mx;
        logic signed [19:0] diff;
        logic [17:0]        mag;
        n_side4 = f_side;
        mn = $signed(f_side.r[0]);
        mx = $signed(f_side.r[0]);
        for (int i = 1; i < 3; i++) begin
            if ($signed(f_side.r[i]) < mn) mn = $signed(f_side.r[i]);
            if ($signed(f_side.r[i]) > mx) mx = $signed(f_side.r[i]);
        end
        for (int i = 0; i < 3; i++) begin
            diff = 20'($signed(f_side.r[i])) - 20'($signed({1'b0, f_side.l}));
            mag  = (diff < 0) ? 18'(-diff) : 18'(diff);
            n_side4.neg[i] = (diff < 0);
            n_prod4[i] = NW'(mag) * NW'(f_side.l);
        end
        n_side4.mx   = mx;
        n_side4.clip = (mn < 0);
        n_den4 = DW'(20'($signed({1'b0, f_side.l})) - 20'(mn));
    end

    ptb_div #(.NW(NW), .DW(DW), .QW(QW), .SW(SW)) u_div_low (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_num   (r_prod4),
        .i_den   (r_den4),
        .i_side  (r_side4),
        .o_valid (d1_valid),
        .o_quo   (d1_quo),
        .o_side  (d1_side)
    );

    assign d1_s = ptb_pkg::t_side'(d1_side);

    // Apply the low clip where the darkest channel went below zero.
    always_comb begin
        logic signed [19:0] qs;
        n_side5 = d1_s;
        for (int i = 0; i < 3; i++) begin
            qs = 20'($signed({2'b0, d1_quo[i]}));
            if (d1_s.neg[i]) qs = -qs;
            if (d1_s.clip) begin
                n_side5.r[i] = 19'(20'($signed({1'b0, d1_s.l})) + qs);
            end
        end
    end

    // High clip setup: distances from luma times the headroom above it.
    always_comb begin
        logic signed [19:0] diff;
        logic [17:0]        mag;
        logic [16:0]        head;
        n_side6 = r_side5;
        head = 17'(ptb_pkg::FX_ONE) - r_side5.l;
        for (int i = 0; i < 3; i++) begin
            diff = 20'($signed(r_side5.r[i])) - 20'($signed({1'b0, r_side5.l}));
            mag  = (diff < 0) ? 18'(-diff) : 18'(diff);
            n_side6.neg[i] = (diff < 0);
            n_prod6[i] = NW'(mag) * NW'(head);
        end
        n_side6.clip = ($signed(r_side5.mx) > ptb_pkg::FX_ONE);
        n_den6 = DW'(20'($signed(r_side5.mx)) - 20'($signed({1'b0, r_side5.l})));
    end

    ptb_div #(.NW(NW), .DW(DW), .QW(QW), .SW(SW)) u_div_high (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_num   (r_prod6),
        .i_den   (r_den6),
        .i_side  (r_side6),
        .o_valid (d2_valid),
        .o_quo   (d2_quo),
        .o_side  (d2_side)
    );

    assign d2_s = ptb_pkg::t_side'(d2_side);

    // Apply the high clip where the brightest channel went above one.
    always_comb begin
        logic signed [19:0] qs;
        n_side7 = d2_s;
        for (int i = 0; i < 3; i++) begin
            qs = 20'($signed({2'b0, d2_quo[i]}));
            if (d2_s.neg[i]) qs = -qs;
            if (d2_s.clip) begin
                n_side7.r[i] = 19'(20'($signed({1'b0, d2_s.l})) + qs);
            end
        end
    end

    // Valid bits of the clip stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v4 <= f_valid;
            r_v5 <= d1_valid;
            r_v6 <= r_v5;
            r_v7 <= d2_valid;
        end
    end

    // Payload registers of the clip stages.
    always_ff @(posedge i_clk) begin
        r_side4 <= n_side4;
        r_prod4 <= n_prod4;
        r_den4  <= n_den4;
        r_side5 <= n_side5;
        r_side6 <= n_side6;
        r_prod6 <= n_prod6;
        r_den6  <= n_den6;
        r_side7 <= n_side7;
    end

    ptb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v7),
        .i_side  (r_side7),
        .i_cfg   (r_cfg),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

    // Every item taken gives exactly one result after the fixed latency.
    `PTB_ASSERT_IMPL(a_item_out, i_clk, i_rst_n, accept, ##LAT o_valid)
    `PTB_ASSERT_IMPL(a_no_extra, i_clk, i_rst_n, o_valid, $past(start && !busy, LAT))
    // Alpha is carried through unchanged.
    `PTB_ASSERT_IMPL(a_alpha, i_clk, i_rst_n, o_valid, o_item.out_alpha == $past(i_item.in_alpha, LAT))
    // A transparent pixel leaves with its red and blue channels untouched.
    `PTB_ASSERT_IMPL(a_clear_pass, i_clk, i_rst_n, o_valid && $past(i_item.in_alpha == 8'd0, LAT), o_item.out_red == $past(i_item.in_red, LAT) && o_item.out_blue == $past(i_item.in_blue, LAT))

endmodule

/* tb/tb_pixel_tint_blend_unit.sv */
// Self-checking pixel tint blend unit testbench: directed table, mode sweep, random pixels.
module tb_pixel_tint_blend_unit;

    localparam int LATENCY = 45;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_RANDOM = 500;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    ptb_pkg::t_pix_in   i_item = '0;
    logic               o_valid;
    ptb_pkg::t_pix_out  o_item;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;

    pixel_tint_blend_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_item(i_item), .o_valid(o_valid), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the layer registers.
    ptb_pkg::t_cfg     layer;
    ptb_pkg::t_pix_out pending_pixels[$];
    int                n_errors = 0;
    int                n_results = 0;
    int                n_items = 0;
    int                idle_cycles = 0;
    bit                timed_out = 1'b0;

    // Q0.16 product rounded to nearest, ties upward, also for negative values.
    function automatic longint fx_rnd(input longint p);
        longint y;
        y = p + ptb_pkg::FX_HALF;
        if (y >= 0) return y >>> ptb_pkg::FRAC_BITS;
        return -(((-y) + ptb_pkg::FX_ONE - 1) >>> ptb_pkg::FRAC_BITS);
    endfunction

    function automatic longint fx_of(input logic [7:0] v);
        return (longint'(v) * ptb_pkg::FX_ONE + 127) / 255;
    endfunction

    function automatic logic [7:0] u8_of(input longint c);
        if (c < 0) c = 0;
        if (c > ptb_pkg::FX_ONE) c = ptb_pkg::FX_ONE;
        return 8'((c * 255 + ptb_pkg::FX_HALF) >>> ptb_pkg::FRAC_BITS);
    endfunction

    function automatic longint luma_of(input longint c[3]);
        return fx_rnd(longint'(ptb_pkg::W_RED) * c[0] + longint'(ptb_pkg::W_GREEN) * c[1]
                      + longint'(ptb_pkg::W_BLUE) * c[2]);
    endfunction

    // Pull the channels toward the luminosity by num/den, truncating.
    function automatic void pull_toward(inout longint c[3], input longint l,
                                        input longint num, input longint den);
        for (int i = 0; i < 3; i++)
            c[i] = (den <= 0) ? l : l + ((c[i] - l) * num) / den;
    endfunction

    // Expected tinted pixel for the current layer registers.
    function automatic ptb_pkg::t_pix_out tint_pixel(input ptb_pkg::t_pix_in p);
        ptb_pkg::t_pix_out q;
        logic [7:0]        orig[3], tnt[3], res[3];
        longint            b[3], s[3], r[3], d, l, mn, mx, op, xe, ye;
        orig = '{p.in_red, p.in_green, p.in_blue};
        tnt = '{layer.tint_rgb[23:16], layer.tint_rgb[15:8], layer.tint_rgb[7:0]};
        res = orig;
        xe = (layer.region_x_end > ptb_pkg::COORD_LIMIT) ? ptb_pkg::COORD_LIMIT
                                                          : layer.region_x_end;
        ye = (layer.region_y_end > ptb_pkg::COORD_LIMIT) ? ptb_pkg::COORD_LIMIT
                                                          : layer.region_y_end;
        if (p.in_alpha != 0 && p.pixel_x >= layer.region_x_start && p.pixel_x < xe
            && p.pixel_y >= layer.region_y_start && p.pixel_y < ye) begin
            for (int i = 0; i < 3; i++) begin
                b[i] = fx_of(orig[i]);
                s[i] = fx_of(tnt[i]);
            end
            if (layer.blend_mode == ptb_pkg::MODE_OVERLAY) begin
                for (int i = 0; i < 3; i++)
                    res[i] = u8_of((b[i] <= ptb_pkg::FX_HALF) ? fx_rnd(2 * b[i] * s[i])
                        : ptb_pkg::FX_ONE - fx_rnd(2 * (ptb_pkg::FX_ONE - b[i])
                                                   * (ptb_pkg::FX_ONE - s[i])));
            end else if (layer.blend_mode == ptb_pkg::MODE_COLOR) begin
                d = luma_of(b) - luma_of(s);
                for (int i = 0; i < 3; i++) r[i] = s[i] + d;
                l = luma_of(r);
                mn = r[0];
                mx = r[0];
                for (int i = 1; i < 3; i++) begin
                    if (r[i] < mn) mn = r[i];
                    if (r[i] > mx) mx = r[i];
                end
                if (mn < 0) pull_toward(r, l, l, l - mn);
                if (mx > ptb_pkg::FX_ONE) pull_toward(r, l, ptb_pkg::FX_ONE - l, mx - l);
                for (int i = 0; i < 3; i++) res[i] = u8_of(r[i]);
            end else begin
                res = tnt;
            end
            op = (layer.opacity > 256) ? 256 : layer.opacity;
            for (int i = 0; i < 3; i++)
                res[i] = 8'((longint'(orig[i]) * (256 - op) + longint'(res[i]) * op
                             + 128) >>> 8);
        end
        q.out_red = res[0];
        q.out_green = res[1];
        q.out_blue = res[2];
        q.out_alpha = p.in_alpha;
        return q;
    endfunction

    // Result checker and watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                n_results++;
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, o_item);
                    n_errors++;
                end else begin
                    ptb_pkg::t_pix_out e;
                    e = pending_pixels.pop_front();
                    if (e.out_red !== o_item.out_red || e.out_green !== o_item.out_green
                        || e.out_blue !== o_item.out_blue
                        || e.out_alpha !== o_item.out_alpha) begin
                        $display("%0t: mismatch expected %h actual %h", $time, e, o_item);
                        n_errors++;
                    end
                end
            end
            if (o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
        end
    end

    // Register write while the block is idle.
    task automatic write_reg(input ptb_pkg::t_cfg_idx idx, input logic [23:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            ptb_pkg::CFG_BLEND_MODE:     layer.blend_mode = value[1:0];
            ptb_pkg::CFG_TINT_RGB:       layer.tint_rgb = value;
            ptb_pkg::CFG_OPACITY:        layer.opacity = value[8:0];
            ptb_pkg::CFG_REGION_X_START: layer.region_x_start = value[12:0];
            ptb_pkg::CFG_REGION_X_END:   layer.region_x_end = value[12:0];
            ptb_pkg::CFG_REGION_Y_START: layer.region_y_start = value[12:0];
            default:                     layer.region_y_end = value[12:0];
        endcase
    endtask

    // Drain all pending results plus the pipeline depth.
    task automatic drain();
        while (pending_pixels.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // Send one pixel, after a random gap if gaps is set; reference is optional.
    task automatic send_pixel(input ptb_pkg::t_pix_in p, input bit has_ref,
                              input ptb_pkg::t_pix_out ref_pix, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start = 1'b1;
        i_item = p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_pixels.push_back(has_ref ? ref_pix : tint_pixel(p));
        n_items++;
    endtask

    function automatic ptb_pkg::t_pix_in make_pix(input int x, input int y,
                                                  input logic [31:0] rgba);
        ptb_pkg::t_pix_in p;
        p.pixel_x = 12'(x);
        p.pixel_y = 12'(y);
        {p.in_red, p.in_green, p.in_blue, p.in_alpha} = rgba;
        return p;
    endfunction

    // Randomize the whole layer, favoring the extremes.
    task automatic random_layer();
        logic [12:0] a, b;
        write_reg(ptb_pkg::CFG_BLEND_MODE, 24'($urandom_range(0, 3)));
        write_reg(ptb_pkg::CFG_TINT_RGB, ($urandom_range(0, 3) == 0) ?
                  24'($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0) : 24'($urandom));
        case ($urandom_range(0, 3))
            0:       write_reg(ptb_pkg::CFG_OPACITY, 24'd256);
            1:       write_reg(ptb_pkg::CFG_OPACITY, 24'($urandom_range(257, 511)));
            default: write_reg(ptb_pkg::CFG_OPACITY, 24'($urandom_range(0, 256)));
        endcase
        for (int k = 0; k < 2; k++) begin
            a = 13'($urandom_range(0, 2048));
            b = 13'($urandom_range(0, 3) == 0 ? $urandom_range(0, 8191)
                                              : $urandom_range(2048, 4096));
            if (k == 0) begin
                write_reg(ptb_pkg::CFG_REGION_X_START, 24'(a));
                write_reg(ptb_pkg::CFG_REGION_X_END, 24'(b));
            end else begin
                write_reg(ptb_pkg::CFG_REGION_Y_START, 24'(a));
                write_reg(ptb_pkg::CFG_REGION_Y_END, 24'(b));
            end
        end
    endtask

    ptb_pkg::t_pix_in  dir_in[12];
    ptb_pkg::t_pix_out dir_out[12];
    bit                dir_known[12];

    initial begin
        ptb_pkg::t_pix_in p;
        layer = '{2'd0, 24'hFFFFFF, 9'd256, 13'd0, 13'd4096, 13'd0, 13'd4096};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table at reset values: overlay with white gives 2b for dark.
        dir_in[0] = make_pix(0, 0, 32'h000000FF);    dir_known[0] = 1;
        dir_out[0] = 32'h000000FF;
        dir_in[1] = make_pix(4095, 4095, 32'hFFFFFFFF); dir_known[1] = 1;
        dir_out[1] = 32'hFFFFFFFF;
        dir_in[2] = make_pix(100, 200, 32'h12345600); dir_known[2] = 1;
        dir_out[2] = 32'h12345600;
        for (int i = 3; i < 12; i++) begin
            dir_in[i] = make_pix(i * 455, 4095 - i * 455, $urandom | 32'h1);
            dir_known[i] = 0;
        end
        for (int i = 0; i < 12; i++)
            send_pixel(dir_in[i], dir_known[i], dir_out[i], 1'b0);
        @(negedge i_clk);
        start = 1'b0;
        drain();

        // Each mode code, edge tints, opacity 300 or 0 (code 3), wide region (empty for code 2).
        for (int m = 0; m < 4; m++) begin
            write_reg(ptb_pkg::CFG_BLEND_MODE, 24'(m));
            write_reg(ptb_pkg::CFG_TINT_RGB, m[0] ? 24'h00FF80 : 24'h000000);
            write_reg(ptb_pkg::CFG_OPACITY, (m == 3) ? 24'd0 : 24'd300);
            write_reg(ptb_pkg::CFG_REGION_X_START, 24'd10);
            write_reg(ptb_pkg::CFG_REGION_X_END, 24'd8191);
            write_reg(ptb_pkg::CFG_REGION_Y_START, 24'd20);
            write_reg(ptb_pkg::CFG_REGION_Y_END, (m == 2) ? 24'd5 : 24'd4096);
            send_pixel(make_pix(9, 20, 32'h80808080), 0, '0, 1'b0);
            send_pixel(make_pix(10, 20, 32'h7F80FF01), 0, '0, 1'b0);
            send_pixel(make_pix(4095, 4095, 32'hFF00FFFF), 0, '0, 1'b0);
            @(negedge i_clk);
            start = 1'b0;
            drain();
        end

        // Random phases, each with a fresh layer; some phases run back to back.
        for (int ph = 0; ph < 10 && !timed_out; ph++) begin
            random_layer();
            for (int i = 0; i < N_RANDOM / 10; i++) begin
                p = make_pix($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
                if ($urandom_range(0, 3) == 0) begin
                    p.pixel_x = 12'($urandom_range(layer.region_x_start,
                                                   layer.region_x_start + 3));
                    p.pixel_y = 12'($urandom_range(layer.region_y_start,
                                                   layer.region_y_start + 3));
                end
                if ($urandom_range(0, 15) == 0) p.in_alpha = 8'd0;
                send_pixel(p, 0, '0, ph[0]);
            end
            @(negedge i_clk);
            start = 1'b0;
            drain();
        end

        if (timed_out) begin
            $display("tb: failure");
            $finish;
        end
        $display("Sent %0d pixels, checked %0d results over all blend modes,", n_items,
                 n_results);
        $display("regions, tints and opacities including the extremes.");
        if (n_errors == 0 && pending_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog exit, independent of the stimulus process.
    initial begin
        wait (timed_out);
        $display("%0t: watchdog expired", $time);
        $display("tb: failure");
        $finish;
    end
endmodule
